### hw/rtl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned PosWidth    = 17;
  localparam int unsigned HeaderBytes = 5;
  localparam int unsigned MinPacket   = 6;
  localparam logic [PosWidth-1:0] PosMax = {PosWidth{1'b1}};

  localparam logic [7:0] StartMarkerReset = 8'h02;

  typedef enum logic [1:0] {
    PosStart    = 2'd0,
    PosCommand  = 2'd1,
    PosResponse = 2'd2
  } hdr_pos_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_START    = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_LEN_MISMATCH = 3'd4
  } frame_status_e;

  typedef struct packed {
    logic          valid;
    kind_e         kind;
    logic [7:0]    data;
    logic [7:0]    command;
    logic [7:0]    response;
    logic [15:0]   length;
    frame_status_e status;
  } res_t;

endpackage

### hw/rtl/sfd_frame.sv
module sfd_frame import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] start_marker_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output res_t       res_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          xor_q, xor_d;
  logic                start_ok_q, start_ok_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [7:0]          rsp_q, rsp_d;
  logic [15:0]         len_q, len_d;

  logic [PosWidth:0]   size_w;
  logic [PosWidth:0]   need_w;
  logic [PosWidth-1:0] data_off_w;
  frame_status_e       status_w;

  assign size_w     = {1'b0, pos_q} + (PosWidth+1)'(1);
  assign need_w     = (PosWidth+1)'(MinPacket) + {{(PosWidth+1-16){1'b0}}, len_q};
  assign data_off_w = pos_q - PosWidth'(HeaderBytes);

  always_comb begin
    if (size_w < (PosWidth+1)'(MinPacket)) begin
      status_w = ST_TOO_SHORT;
    end else if (!start_ok_q) begin
      status_w = ST_BAD_START;
    end else if (xor_q != byte_i) begin
      status_w = ST_BAD_CHECKSUM;
    end else if (size_w < need_w) begin
      status_w = ST_LEN_MISMATCH;
    end else begin
      status_w = ST_OK;
    end
  end

  always_comb begin
    pos_d      = pos_q;
    xor_d      = xor_q;
    start_ok_d = start_ok_q;
    cmd_d      = cmd_q;
    rsp_d      = rsp_q;
    len_d      = len_q;
    res_o      = '0;
    if (last_i) begin
      pos_d      = '0;
      xor_d      = '0;
      start_ok_d = 1'b0;
      cmd_d      = '0;
      rsp_d      = '0;
      len_d      = '0;
      res_o.valid  = 1'b1;
      res_o.kind   = KIND_STATUS;
      res_o.status = status_w;
      if (status_w == ST_OK || status_w == ST_LEN_MISMATCH) begin
        res_o.command  = cmd_q;
        res_o.response = rsp_q;
        res_o.length   = len_q;
      end
    end else begin
      if (pos_q == PosWidth'(PosStart)) begin
        start_ok_d = (byte_i == start_marker_i);
      end
      if (pos_q == PosWidth'(PosCommand)) begin
        cmd_d = byte_i;
      end
      if (pos_q == PosWidth'(PosResponse)) begin
        rsp_d = byte_i;
      end
      if (pos_q == PosWidth'(HeaderBytes - 2)) begin
        len_d = {byte_i, 8'h00};
      end
      if (pos_q == PosWidth'(HeaderBytes - 1)) begin
        len_d = {len_q[15:8], byte_i};
      end
      xor_d = xor_q ^ byte_i;
      if (pos_q != PosMax) begin
        pos_d = pos_q + PosWidth'(1);
      end
      if (pos_q >= PosWidth'(HeaderBytes) &&
          data_off_w < {{(PosWidth-16){1'b0}}, len_q}) begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_DATA;
        res_o.data  = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      xor_q      <= '0;
      start_ok_q <= 1'b0;
      cmd_q      <= '0;
      rsp_q      <= '0;
      len_q      <= '0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      start_ok_q <= start_ok_d;
      cmd_q      <= cmd_d;
      rsp_q      <= rsp_d;
      len_q      <= len_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && xor_q == '0 && !start_ok_q)
    else $error("framing state not cleared after final beat");

  a_no_data_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == KIND_DATA |-> pos_q >= PosWidth'(HeaderBytes) && !last_i)
    else $error("data result from a header or final beat");

  a_pos_moves_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && pos_q != PosMax |=> pos_q == $past(pos_q) + PosWidth'(1))
    else $error("position did not advance by one");

endmodule

### hw/rtl/stx_frame_deframer_xor_check_top.sv
// Packet deframer with XOR checksum check.
// Input channel: one packet byte per beat on in_byte_i, with in_last_i set on
// the final beat, which carries the checksum. Output channel: one result per
// beat, either a data byte (out_kind_o low) or an end-of-packet status (high)
// with command, response code and data length captured on an OK or length
// mismatch. Header beats and bytes past the data length produce no result.
// The start marker register is written through the cfg channel, which is
// always ready; it must only be written while no packet byte is in flight.
// An accepted beat is held in the input register; its result is registered in
// the result register when the beat advances. Throughput is one beat per cycle
// with a ready receiver, set by the single input and single result registers.
// When the receiver stalls, the result register holds. Beats that produce no
// result still pass, but the first beat that needs the result register waits
// in the input register with in_ready_o low until the pending result is taken.
// Reset clears the framing state, empties both registers and restores the
// start marker to 0x02.
module stx_frame_deframer_xor_check_top import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  command_code_o,
  output logic [7:0]  response_code_o,
  output logic [15:0] data_length_o,
  output logic [2:0]  frame_status_o
);

  logic [7:0] marker_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  res_t       res_w;
  logic       advance_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= StartMarkerReset;
    end else if (cfg_valid_i) begin
      marker_q <= cfg_data_i;
    end
  end

  sfd_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_marker_i (marker_q),
    .step_i         (advance_w),
    .byte_i         (s1_byte_q),
    .last_i         (s1_last_q),
    .res_o          (res_w)
  );

  assign advance_w   = s1_valid_q && (!res_w.valid || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance_w;
  assign out_valid_d = (advance_w && res_w.valid) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_last_q <= in_last_i;
    end
    if (advance_w && res_w.valid) begin
      res_q <= res_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = res_q.kind;
  assign out_byte_o      = res_q.data;
  assign command_code_o  = res_q.command;
  assign response_code_o = res_q.response;
  assign data_length_o   = res_q.length;
  assign frame_status_o  = res_q.status;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty input register");

  a_data_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KIND_DATA |->
      res_q.status == ST_OK && res_q.command == '0 && res_q.length == '0)
    else $error("data result carries status fields");

  a_failed_status_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == KIND_STATUS &&
      (res_q.status == ST_TOO_SHORT || res_q.status == ST_BAD_START ||
       res_q.status == ST_BAD_CHECKSUM) |->
      res_q.command == '0 && res_q.response == '0 && res_q.length == '0 &&
      res_q.data == '0)
    else $error("failed status result carries captured header fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> res_q == $past(res_q))
    else $error("pending result overwritten");

endmodule
